[rtl/pls_pkg.sv]
// ----------------------------------------------------------------------------
// pls_pkg
// Shared types and constants for the positional list store.
// ----------------------------------------------------------------------------
package pls_pkg;

   localparam int unsigned DEF_CAPACITY = 16;
   localparam int unsigned VALUE_W      = 32;
   localparam int unsigned POS_W        = 5;
   localparam int unsigned CMD_W        = 3;
   localparam int unsigned STATUS_W     = 2;
   localparam int unsigned REQ_DATA_W   = 40;
   localparam int unsigned RSP_DATA_W   = 104;

   localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_INSERT     = 3'd4;
   localparam logic [CMD_W-1:0] CMD_DELETE     = 3'd5;
   localparam logic [CMD_W-1:0] CMD_READ       = 3'd6;

   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

   localparam logic [VALUE_W-1:0] NONE_VALUE = '1;

   // per-cycle move order broadcast along the row of cells
   typedef struct packed {
      logic shift_up;    // open a slot at the insert point
      logic shift_down;  // close the slot at the delete point
   } cell_cmd_type;

endpackage

[rtl/pls_cell.sv]
// ----------------------------------------------------------------------------
// pls_cell
// One list slot: holds a value, takes from its left or right neighbor on
// insert or delete, and offers its value to the read and back selectors.
// ----------------------------------------------------------------------------
module pls_cell #(
   parameter int unsigned IDX_W = 4
) (
   input  logic                         clock,
   input  pls_pkg::cell_cmd_type        cmd,
   input  logic [IDX_W-1:0]             cell_index,
   input  logic [IDX_W-1:0]             at,
   input  logic [pls_pkg::VALUE_W-1:0]  new_value,
   input  logic [pls_pkg::VALUE_W-1:0]  left_value,
   input  logic [pls_pkg::VALUE_W-1:0]  right_value,
   input  logic [IDX_W-1:0]             read_pos,
   input  logic [IDX_W-1:0]             back_pos,
   output logic [pls_pkg::VALUE_W-1:0]  value_out,
   output logic [pls_pkg::VALUE_W-1:0]  read_term,
   output logic [pls_pkg::VALUE_W-1:0]  back_term
);
   import pls_pkg::*;

   logic [VALUE_W-1:0] value_ff;
   logic [VALUE_W-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      if (cmd.shift_up) begin
         if (cell_index > at) begin
            value_in = left_value;
         end else if (cell_index == at) begin
            value_in = new_value;
         end
      end else if (cmd.shift_down) begin
         if (cell_index >= at) begin
            value_in = right_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value_out = value_ff;
   assign read_term = (cell_index == read_pos) ? value_ff : '0;
   assign back_term = (cell_index == back_pos) ? value_ff : '0;

endmodule

[rtl/positional_list_store_unit.sv]
// ----------------------------------------------------------------------------
// positional_list_store_unit
// Ordered list of signed 32-bit values with push, pop, insert, delete, read.
// ----------------------------------------------------------------------------
// On accepting a command the whole row of cells shifts by one place at once
// (insert or delete at any position); once the result register is free, the
// read, front and back values are picked from the updated row into the result
// register. The block takes no new item until that result is loaded; the
// result register lets one finished item wait while the next is accepted.
// No clearing pass is needed after reset.
module positional_list_store_unit #(
   parameter int unsigned CAPACITY = pls_pkg::DEF_CAPACITY
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // command [2:0], position [7:3], item_value [39:8]
   input  logic [pls_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // status [1:0], read_value [33:2], entry_count [38:34],
   // front_value [70:39], back_value [102:71], zero [103]
   output logic [pls_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import pls_pkg::*;

   localparam int unsigned LEN_W = $clog2(CAPACITY + 1);
   localparam int unsigned IDX_W = $clog2(CAPACITY);
   localparam int unsigned CMP_W = (LEN_W > POS_W) ? LEN_W : POS_W;

   logic [CMD_W-1:0]   req_cmd;
   logic [POS_W-1:0]   req_pos;
   logic [VALUE_W-1:0] req_value;
   logic               accept;

   assign req_cmd   = req_tdata[CMD_W-1:0];
   assign req_pos   = req_tdata[CMD_W+POS_W-1:CMD_W];
   assign req_value = req_tdata[CMD_W+POS_W+VALUE_W-1:CMD_W+POS_W];

   logic               busy_ff, busy_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic               rd_ok_ff, rd_ok_in;
   logic [IDX_W-1:0]   rd_pos_ff, rd_pos_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   assign req_tready = !busy_ff;
   assign accept     = req_tvalid && req_tready;

   // decode against the current length
   logic [CMP_W-1:0]   pos_c, len_c;
   logic               is_empty, is_full;
   cell_cmd_type       cmd;
   logic [IDX_W-1:0]   at;
   logic [STATUS_W-1:0] status_dec;
   logic               rd_ok_dec;

   assign pos_c    = CMP_W'(req_pos);
   assign len_c    = CMP_W'(len_ff);
   assign is_empty = (len_ff == '0);
   assign is_full  = (len_ff == LEN_W'(CAPACITY));

   always_comb begin
      cmd        = '0;
      at         = '0;
      status_dec = ST_OK;
      rd_ok_dec  = 1'b0;
      case (req_cmd)
         CMD_PUSH_FRONT: begin
            if (is_full) begin
               status_dec = ST_FULL;
            end else begin
               cmd.shift_up = 1'b1;
            end
         end
         CMD_PUSH_BACK: begin
            at = IDX_W'(len_ff);
            if (is_full) begin
               status_dec = ST_FULL;
            end else begin
               cmd.shift_up = 1'b1;
            end
         end
         CMD_POP_FRONT: begin
            if (is_empty) begin
               status_dec = ST_EMPTY;
            end else begin
               cmd.shift_down = 1'b1;
            end
         end
         CMD_POP_BACK: begin
            at = IDX_W'(len_ff - LEN_W'(1));
            if (is_empty) begin
               status_dec = ST_EMPTY;
            end else begin
               cmd.shift_down = 1'b1;
            end
         end
         CMD_INSERT: begin
            at = IDX_W'(req_pos);
            if (pos_c > len_c) begin
               status_dec = ST_BADPOS;
            end else if (is_full) begin
               status_dec = ST_FULL;
            end else begin
               cmd.shift_up = 1'b1;
            end
         end
         CMD_DELETE: begin
            at = IDX_W'(req_pos);
            if (is_empty) begin
               status_dec = ST_EMPTY;
            end else if (pos_c >= len_c) begin
               status_dec = ST_BADPOS;
            end else begin
               cmd.shift_down = 1'b1;
            end
         end
         CMD_READ: begin
            if (is_empty) begin
               status_dec = ST_EMPTY;
            end else if (pos_c >= len_c) begin
               status_dec = ST_BADPOS;
            end else begin
               rd_ok_dec = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   cell_cmd_type cell_cmd;
   assign cell_cmd.shift_up   = accept && cmd.shift_up;
   assign cell_cmd.shift_down = accept && cmd.shift_down;

   // row of cells
   logic [VALUE_W-1:0] cell_value [CAPACITY];
   logic [VALUE_W-1:0] read_term  [CAPACITY];
   logic [VALUE_W-1:0] back_term  [CAPACITY];
   logic [IDX_W-1:0]   back_pos;

   assign back_pos = IDX_W'(len_ff - LEN_W'(1));

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [VALUE_W-1:0] left_v, right_v;
      if (i == 0) begin : g_first
         assign left_v = req_value;
      end else begin : g_mid_l
         assign left_v = cell_value[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_v = cell_value[i];
      end else begin : g_mid_r
         assign right_v = cell_value[i+1];
      end
      pls_cell #(.IDX_W(IDX_W)) u_cell (
         .clock       (clock),
         .cmd         (cell_cmd),
         .cell_index  (IDX_W'(i)),
         .at          (at),
         .new_value   (req_value),
         .left_value  (left_v),
         .right_value (right_v),
         .read_pos    (rd_pos_ff),
         .back_pos    (back_pos),
         .value_out   (cell_value[i]),
         .read_term   (read_term[i]),
         .back_term   (back_term[i])
      );
   end

   logic [VALUE_W-1:0] read_sel, back_sel;
   always_comb begin
      read_sel = '0;
      back_sel = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         read_sel = read_sel | read_term[i];
         back_sel = back_sel | back_term[i];
      end
   end

   // control and length
   logic load_rsp;
   assign load_rsp = busy_ff && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      busy_in   = busy_ff;
      len_in    = len_ff;
      status_in = status_ff;
      rd_ok_in  = rd_ok_ff;
      rd_pos_in = rd_pos_ff;
      if (accept) begin
         busy_in   = 1'b1;
         status_in = status_dec;
         rd_ok_in  = rd_ok_dec;
         rd_pos_in = IDX_W'(req_pos);
         if (cmd.shift_up) begin
            len_in = len_ff + LEN_W'(1);
         end else if (cmd.shift_down) begin
            len_in = len_ff - LEN_W'(1);
         end
      end else if (load_rsp) begin
         busy_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {1'b0,
                         is_empty ? NONE_VALUE : back_sel,
                         is_empty ? NONE_VALUE : cell_value[0],
                         POS_W'(len_ff),
                         rd_ok_ff ? read_sel : NONE_VALUE,
                         status_ff};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff   <= status_in;
      rd_ok_ff    <= rd_ok_in;
      rd_pos_ff   <= rd_pos_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
